/* sv/rrns_pkg.sv */
// ----------------------------------------------------------------------------
// rrns_pkg
// Shared types and constants for the nearest-neighbor rectangle scale
// address generator.
// ----------------------------------------------------------------------------
package rrns_pkg;

   // image size defaults
   localparam int DEF_SRC_WIDTH  = 1024;
   localparam int DEF_SRC_HEIGHT = 1024;
   localparam int DEF_DST_WIDTH  = 1024;
   localparam int DEF_DST_HEIGHT = 1024;

   localparam int REG_W    = 13;             // config register width
   localparam int REG_NUM  = 8;
   localparam int CSR_AW   = 5;              // byte address, 4 bytes per reg
   localparam int CSR_DW   = 32;
   localparam int IDX_W    = 12;             // loop index width
   localparam int NUM_W    = IDX_W + REG_W;  // index * size
   localparam int QUO_W    = REG_W;          // quotient stays below a size
   localparam int SUM_W    = REG_W + 2;      // signed origin + offset
   localparam int COORD_W  = 12;             // in-image coordinate
   localparam int LIN_W    = 2 * COORD_W;    // row * width + col
   localparam int MUL3_W   = LIN_W + 2;
   localparam int OUT_CW   = 10;
   localparam int OUT_AW   = 22;

   typedef enum logic [2:0] {
      REG_SRC_LEFT   = 3'd0,
      REG_SRC_TOP    = 3'd1,
      REG_SRC_WIDTH  = 3'd2,
      REG_SRC_HEIGHT = 3'd3,
      REG_DST_LEFT   = 3'd4,
      REG_DST_TOP    = 3'd5,
      REG_DST_WIDTH  = 3'd6,
      REG_DST_HEIGHT = 3'd7
   } reg_idx_type;

   // copy: equal sizes; shrink: walk source; grow: walk destination
   typedef enum logic [1:0] {
      MODE_COPY   = 2'd0,
      MODE_SHRINK = 2'd1,
      MODE_GROW   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [IDX_W-1:0] row_index;
      logic [IDX_W-1:0] col_index;
   } req_data_type;

   typedef struct packed {
      logic [3:0]        pad;
      logic [OUT_AW-1:0] dst_byte_addr;
      logic [OUT_AW-1:0] src_byte_addr;
      logic [OUT_CW-1:0] dst_row;
      logic [OUT_CW-1:0] dst_col;
      logic [OUT_CW-1:0] src_row;
      logic [OUT_CW-1:0] src_col;
   } rsp_data_type;

   typedef struct packed {
      logic             ok;
      mode_type         mode;
      logic [IDX_W-1:0] ci;
      logic [IDX_W-1:0] ri;
   } idx_stage_type;

   typedef struct packed {
      logic             ok;
      mode_type         mode;
      logic [IDX_W-1:0] ci;
      logic [IDX_W-1:0] ri;
      logic [NUM_W-1:0] rem_c;
      logic [NUM_W-1:0] rem_r;
      logic [REG_W-1:0] dvs_c;
      logic [REG_W-1:0] dvs_r;
      logic [QUO_W-1:0] q_c;
      logic [QUO_W-1:0] q_r;
   } div_stage_type;

   typedef struct packed {
      logic               ok;
      logic [COORD_W-1:0] sc;
      logic [COORD_W-1:0] sr;
      logic [COORD_W-1:0] dc;
      logic [COORD_W-1:0] dr;
   } crd_stage_type;

   typedef struct packed {
      logic               ok;
      logic [COORD_W-1:0] sc;
      logic [COORD_W-1:0] sr;
      logic [COORD_W-1:0] dc;
      logic [COORD_W-1:0] dr;
      logic [LIN_W-1:0]   s_lin;
      logic [LIN_W-1:0]   d_lin;
   } lin_stage_type;

endpackage

/* sv/rgb_rect_nearest_scale_addr.sv */
// ----------------------------------------------------------------------------
// rgb_rect_nearest_scale_addr
// Pixel address generator for a clipped nearest-neighbor RGB rectangle blit.
// ----------------------------------------------------------------------------
//
//  channel  dir   handshake            payload
//  req_     in    tvalid/tready        tdata: col_index, row_index
//  rsp_     out   tvalid/tready        tdata: coords + byte addrs, tuser: we
//  csr_     in    APB write/read       8 x 13-bit geometry registers
//
// One transaction accepted per clock while rsp_ is not stalled. The depth comes
// from the restoring divider for floor(index*num/den): one quotient bit per
// stage, 13 stages, both axes side by side.
// Reset (synchronous) empties the pipeline and loads origins 0, sizes 1.
// A stall on rsp_ freezes every stage at once; req_tready drops with it.
// The user must rewrite geometry registers only while nothing is in flight; the block does not enforce it.
//
module rgb_rect_nearest_scale_addr #(
   parameter int SRC_WIDTH  = rrns_pkg::DEF_SRC_WIDTH,
   parameter int SRC_HEIGHT = rrns_pkg::DEF_SRC_HEIGHT,
   parameter int DST_WIDTH  = rrns_pkg::DEF_DST_WIDTH,
   parameter int DST_HEIGHT = rrns_pkg::DEF_DST_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   // request: [11:0] col_index, [23:12] row_index
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,
   // response: [9:0] src_col, [19:10] src_row, [29:20] dst_col,
   // [39:30] dst_row, [61:40] src_byte_addr, [83:62] dst_byte_addr, zero pad
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [87:0]                 rsp_tdata,
   // response: [0] write_enable
   output logic [0:0]                  rsp_tuser,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rrns_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [rrns_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [rrns_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import rrns_pkg::*;

   // ---------------------------------------------------------------- regs
   logic [REG_W-1:0] cfg_ff [REG_NUM];
   logic             csr_wr;
   reg_idx_type      csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_idx_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = {{(CSR_DW-REG_W){1'b0}}, cfg_ff[csr_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_SRC_LEFT]   <= '0;
         cfg_ff[REG_SRC_TOP]    <= '0;
         cfg_ff[REG_SRC_WIDTH]  <= REG_W'(1);
         cfg_ff[REG_SRC_HEIGHT] <= REG_W'(1);
         cfg_ff[REG_DST_LEFT]   <= '0;
         cfg_ff[REG_DST_TOP]    <= '0;
         cfg_ff[REG_DST_WIDTH]  <= REG_W'(1);
         cfg_ff[REG_DST_HEIGHT] <= REG_W'(1);
      end else if (csr_wr) begin
         cfg_ff[csr_idx] <= csr_pwdata[REG_W-1:0];
      end
   end

   logic [REG_W-1:0] sw, sh, dw, dh;
   assign sw = cfg_ff[REG_SRC_WIDTH];
   assign sh = cfg_ff[REG_SRC_HEIGHT];
   assign dw = cfg_ff[REG_DST_WIDTH];
   assign dh = cfg_ff[REG_DST_HEIGHT];

   // ------------------------------------------------------- flow control
   // every stage moves together; the output register frees the input
   // whenever it is empty or being drained
   logic advance;
   logic out_v_ff;

   assign advance    = ~out_v_ff | rsp_tready;
   assign req_tready = advance;

   // ------------------------------------------- stage 0: mode and bounds
   req_data_type  req_d;
   idx_stage_type idx_in, idx_ff;
   logic          idx_v_ff;
   logic [REG_W-1:0] lim_c, lim_r;

   assign req_d = req_data_type'(req_tdata);

   always_comb begin
      idx_in.ci = req_d.col_index;
      idx_in.ri = req_d.row_index;
      if (sw == dw && sh == dh)
         idx_in.mode = MODE_COPY;
      else if (sw > dw && sh > dh)
         idx_in.mode = MODE_SHRINK;
      else
         idx_in.mode = MODE_GROW;
      // index walks the source when shrinking, else the destination
      lim_c = (idx_in.mode == MODE_SHRINK) ? sw : dw;
      lim_r = (idx_in.mode == MODE_SHRINK) ? sh : dh;
      idx_in.ok = (sw != '0) && (sh != '0) && (dw != '0) && (dh != '0) &&
                  ({1'b0, idx_in.ci} < lim_c) && ({1'b0, idx_in.ri} < lim_r);
   end

   always_ff @(posedge clock) begin
      if (reset)
         idx_v_ff <= 1'b0;
      else if (advance)
         idx_v_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (advance)
         idx_ff <= idx_in;
   end

   // ------------------------------------ stage 1: numerator = index * size
   div_stage_type div_in [QUO_W+1];
   div_stage_type div_ff [QUO_W+1];
   logic          div_v_ff [QUO_W+1];

   always_comb begin
      logic [REG_W-1:0] mul_c, mul_r;
      mul_c = (idx_ff.mode == MODE_SHRINK) ? dw : sw;
      mul_r = (idx_ff.mode == MODE_SHRINK) ? dh : sh;
      div_in[0].ok    = idx_ff.ok;
      div_in[0].mode  = idx_ff.mode;
      div_in[0].ci    = idx_ff.ci;
      div_in[0].ri    = idx_ff.ri;
      div_in[0].rem_c = NUM_W'(idx_ff.ci) * NUM_W'(mul_c);
      div_in[0].rem_r = NUM_W'(idx_ff.ri) * NUM_W'(mul_r);
      div_in[0].dvs_c = (idx_ff.mode == MODE_SHRINK) ? sw : dw;
      div_in[0].dvs_r = (idx_ff.mode == MODE_SHRINK) ? sh : dh;
      div_in[0].q_c   = '0;
      div_in[0].q_r   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         div_v_ff[0] <= 1'b0;
      else if (advance)
         div_v_ff[0] <= idx_v_ff;
   end

   always_ff @(posedge clock) begin
      if (advance)
         div_ff[0] <= div_in[0];
   end

   // ----------------------------- divider: one quotient bit per stage
   // index < span keeps the quotient below the other size, so 13 bits do
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int BIT = QUO_W - 1 - k;

      always_comb begin
         logic [NUM_W-1:0] trial_c, trial_r;
         trial_c = NUM_W'(div_ff[k].dvs_c) << BIT;
         trial_r = NUM_W'(div_ff[k].dvs_r) << BIT;
         div_in[k+1] = div_ff[k];
         if (div_ff[k].rem_c >= trial_c) begin
            div_in[k+1].rem_c    = div_ff[k].rem_c - trial_c;
            div_in[k+1].q_c[BIT] = 1'b1;
         end
         if (div_ff[k].rem_r >= trial_r) begin
            div_in[k+1].rem_r    = div_ff[k].rem_r - trial_r;
            div_in[k+1].q_r[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset)
            div_v_ff[k+1] <= 1'b0;
         else if (advance)
            div_v_ff[k+1] <= div_v_ff[k];
      end

      always_ff @(posedge clock) begin
         if (advance)
            div_ff[k+1] <= div_in[k+1];
      end
   end

   // ------------------------------- coordinates and image clipping
   div_stage_type dq;
   crd_stage_type crd_in, crd_ff;
   logic          crd_v_ff;

   assign dq = div_ff[QUO_W];

   always_comb begin
      logic [REG_W-1:0] off_sc, off_sr, off_dc, off_dr;
      logic [SUM_W-1:0] s_c, s_r, d_c, d_r;
      logic             in_s, in_d;
      // scaled side takes the quotient, walked side the plain index
      off_sc = (dq.mode == MODE_GROW)   ? dq.q_c : {1'b0, dq.ci};
      off_sr = (dq.mode == MODE_GROW)   ? dq.q_r : {1'b0, dq.ri};
      off_dc = (dq.mode == MODE_SHRINK) ? dq.q_c : {1'b0, dq.ci};
      off_dr = (dq.mode == MODE_SHRINK) ? dq.q_r : {1'b0, dq.ri};
      s_c = {{2{cfg_ff[REG_SRC_LEFT][REG_W-1]}}, cfg_ff[REG_SRC_LEFT]} +
            {2'b00, off_sc};
      s_r = {{2{cfg_ff[REG_SRC_TOP][REG_W-1]}}, cfg_ff[REG_SRC_TOP]} +
            {2'b00, off_sr};
      d_c = {{2{cfg_ff[REG_DST_LEFT][REG_W-1]}}, cfg_ff[REG_DST_LEFT]} +
            {2'b00, off_dc};
      d_r = {{2{cfg_ff[REG_DST_TOP][REG_W-1]}}, cfg_ff[REG_DST_TOP]} +
            {2'b00, off_dr};
      in_s = ~s_c[SUM_W-1] && (s_c[SUM_W-2:0] < (SUM_W-1)'(SRC_WIDTH)) &&
             ~s_r[SUM_W-1] && (s_r[SUM_W-2:0] < (SUM_W-1)'(SRC_HEIGHT));
      in_d = ~d_c[SUM_W-1] && (d_c[SUM_W-2:0] < (SUM_W-1)'(DST_WIDTH)) &&
             ~d_r[SUM_W-1] && (d_r[SUM_W-2:0] < (SUM_W-1)'(DST_HEIGHT));
      crd_in.ok = dq.ok & in_s & in_d;
      crd_in.sc = s_c[COORD_W-1:0];
      crd_in.sr = s_r[COORD_W-1:0];
      crd_in.dc = d_c[COORD_W-1:0];
      crd_in.dr = d_r[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset)
         crd_v_ff <= 1'b0;
      else if (advance)
         crd_v_ff <= div_v_ff[QUO_W];
   end

   always_ff @(posedge clock) begin
      if (advance)
         crd_ff <= crd_in;
   end

   // ------------------------------------ linear pixel index, row major
   lin_stage_type lin_in, lin_ff;
   logic          lin_v_ff;

   always_comb begin
      lin_in.ok    = crd_ff.ok;
      lin_in.sc    = crd_ff.sc;
      lin_in.sr    = crd_ff.sr;
      lin_in.dc    = crd_ff.dc;
      lin_in.dr    = crd_ff.dr;
      lin_in.s_lin = LIN_W'(crd_ff.sr) * LIN_W'(SRC_WIDTH) + LIN_W'(crd_ff.sc);
      lin_in.d_lin = LIN_W'(crd_ff.dr) * LIN_W'(DST_WIDTH) + LIN_W'(crd_ff.dc);
   end

   always_ff @(posedge clock) begin
      if (reset)
         lin_v_ff <= 1'b0;
      else if (advance)
         lin_v_ff <= crd_v_ff;
   end

   always_ff @(posedge clock) begin
      if (advance)
         lin_ff <= lin_in;
   end

   // --------------------------------- output: 3 bytes/pixel, zero if off
   rsp_data_type rsp_in, rsp_ff;
   logic         we_ff;

   always_comb begin
      logic [MUL3_W-1:0] sa, da;
      sa = (MUL3_W'(lin_ff.s_lin) << 1) + MUL3_W'(lin_ff.s_lin);
      da = (MUL3_W'(lin_ff.d_lin) << 1) + MUL3_W'(lin_ff.d_lin);
      rsp_in = '0;
      if (lin_ff.ok) begin
         rsp_in.src_col       = lin_ff.sc[OUT_CW-1:0];
         rsp_in.src_row       = lin_ff.sr[OUT_CW-1:0];
         rsp_in.dst_col       = lin_ff.dc[OUT_CW-1:0];
         rsp_in.dst_row       = lin_ff.dr[OUT_CW-1:0];
         rsp_in.src_byte_addr = sa[OUT_AW-1:0];
         rsp_in.dst_byte_addr = da[OUT_AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_v_ff <= 1'b0;
      else if (advance)
         out_v_ff <= lin_v_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
         we_ff  <= lin_ff.ok;
      end
   end

   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = rsp_ff;
   assign rsp_tuser[0] = we_ff;

endmodule

/* sv/rrns_check.sv */
// ----------------------------------------------------------------------------
// rrns_check
// Port-level checks for the rectangle scale address generator, bound in.
// ----------------------------------------------------------------------------
module rrns_check #(
   parameter int SRC_WIDTH  = rrns_pkg::DEF_SRC_WIDTH,
   parameter int SRC_HEIGHT = rrns_pkg::DEF_SRC_HEIGHT,
   parameter int DST_WIDTH  = rrns_pkg::DEF_DST_WIDTH,
   parameter int DST_HEIGHT = rrns_pkg::DEF_DST_HEIGHT
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);
   import rrns_pkg::*;

   localparam bit SRC_FITS = (SRC_WIDTH <= 1024) && (SRC_HEIGHT <= 1024);
   localparam bit DST_FITS = (DST_WIDTH <= 1024) && (DST_HEIGHT <= 1024);

   rsp_data_type d;
   logic [31:0]  s_exp, d_exp;

   assign d     = rsp_data_type'(rsp_tdata);
   assign s_exp = (32'(d.src_row) * 32'(SRC_WIDTH) + 32'(d.src_col)) * 32'd3;
   assign d_exp = (32'(d.dst_row) * 32'(DST_WIDTH) + 32'(d.dst_col)) * 32'd3;

   // suppressed pixel carries an all-zero payload
   a_zero_when_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("disabled response has nonzero payload");

   // byte addresses agree with the reported coordinates
   a_src_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && SRC_FITS |->
         d.src_byte_addr == s_exp[OUT_AW-1:0])
      else $error("source byte address does not match coordinates");

   a_dst_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && DST_FITS |->
         d.dst_byte_addr == d_exp[OUT_AW-1:0])
      else $error("destination byte address does not match coordinates");

   // an empty output stage never blocks the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no response pending");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind rgb_rect_nearest_scale_addr rrns_check #(
   .SRC_WIDTH  (SRC_WIDTH),
   .SRC_HEIGHT (SRC_HEIGHT),
   .DST_WIDTH  (DST_WIDTH),
   .DST_HEIGHT (DST_HEIGHT)
) u_rrns_check (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-neighbor rectangle scale address
// generator. Geometry is loaded over the register port while the pipeline
// is empty. Each request transaction is mapped to its expected pixel pair
// on acceptance. Response transactions are compared in order, field by
// field. Both stream sides idle at random, except for one calm stretch.
// ----------------------------------------------------------------------------
module testbench;

   import rrns_pkg::*;

   localparam int IDLE_PCT   = 11;    // chance of a gap or stall per cycle
   localparam int IDLE_LIMIT = 2000;  // cycles with no transaction at all
   localparam int CALM_FROM  = 700;   // request count bounds of the calm run
   localparam int CALM_TO    = 1000;
   localparam int DRAIN_WAIT = 40;    // longer than the pipeline latency

   typedef enum {CMD_PIXEL, CMD_WRITE, CMD_DRAIN} cmd_kind_type;
   typedef enum {APB_IDLE, APB_WR_SETUP, APB_WR_ACCESS, APB_RD_SETUP, APB_RD_ACCESS}
      apb_step_type;

   // one entry of the stimulus queue: a loop index pair, a register write,
   // or a hold until every response is back
   typedef struct {
      cmd_kind_type     kind;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] row;
      reg_idx_type      csr_sel;
      logic [REG_W-1:0] value;
   } bus_cmd_type;

   typedef struct {
      rsp_data_type coords;
      logic         we;
   } pixel_map_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata = '0;    // [11:0] col_index, [23:12] row_index
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [87:0]         rsp_tdata;         // src_col, src_row, dst_col, dst_row,
                                           // src_byte_addr, dst_byte_addr, pad
   logic [0:0]          rsp_tuser;         // [0] write_enable
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   bus_cmd_type         bus_cmds[$];        // stimulus not yet driven
   pixel_map_type       expected_maps[$];   // mappings awaiting their response
   logic [REG_W-1:0]    geom [REG_NUM];     // shadow of the geometry registers
   apb_step_type        apb_step = APB_IDLE;
   int                  sent_items = 0;
   int                  mismatches = 0;
   int                  quiet_cycles = 0;
   logic                calm;

   rgb_rect_nearest_scale_addr DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // no gaps and no stalls for a stretch of requests in the middle of the run
   assign calm = (sent_items >= CALM_FROM) && (sent_items < CALM_TO);

   // ------------------------------------------------------------------------
   // Expected mapping of one index pair under the current geometry.
   // Modes: equal sizes copy 1:1; source larger on both axes walks the
   // source and scales down; anything else walks the destination.
   // ------------------------------------------------------------------------
   function automatic bit walk_axis(input mode_type mode, input longint idx,
                                    input longint s_org, input longint s_len,
                                    input longint d_org, input longint d_len,
                                    output longint s_pos, output longint d_pos);
      s_pos = 0;
      d_pos = 0;
      case (mode)
         MODE_SHRINK: begin
            if (idx >= s_len) return 1'b0;
            s_pos = s_org + idx;
            d_pos = d_org + (idx * d_len) / s_len;
         end
         MODE_GROW: begin
            if (idx >= d_len) return 1'b0;
            d_pos = d_org + idx;
            s_pos = s_org + (idx * s_len) / d_len;
         end
         default: begin
            if (idx >= d_len) return 1'b0;
            s_pos = s_org + idx;
            d_pos = d_org + idx;
         end
      endcase
      return 1'b1;
   endfunction

   function automatic pixel_map_type map_pixel(input logic [IDX_W-1:0] ci,
                                               input logic [IDX_W-1:0] ri);
      pixel_map_type res;
      longint        sl, st, sw, sh, dl, dt, dw, dh;
      longint        sc, sr, dc, dr;
      mode_type      mode;
      bit            ok;
      sl = longint'(signed'(geom[REG_SRC_LEFT]));
      st = longint'(signed'(geom[REG_SRC_TOP]));
      dl = longint'(signed'(geom[REG_DST_LEFT]));
      dt = longint'(signed'(geom[REG_DST_TOP]));
      sw = longint'(geom[REG_SRC_WIDTH]);
      sh = longint'(geom[REG_SRC_HEIGHT]);
      dw = longint'(geom[REG_DST_WIDTH]);
      dh = longint'(geom[REG_DST_HEIGHT]);
      res.coords = '0;
      res.we = 1'b0;
      // a zero-sized rectangle copies nothing
      ok = (sw != 0) && (sh != 0) && (dw != 0) && (dh != 0);
      if (sw == dw && sh == dh)
         mode = MODE_COPY;
      else if (sw > dw && sh > dh)
         mode = MODE_SHRINK;
      else
         mode = MODE_GROW;
      if (ok) ok = walk_axis(mode, longint'(ci), sl, sw, dl, dw, sc, dc);
      if (ok) ok = walk_axis(mode, longint'(ri), st, sh, dt, dh, sr, dr);
      // clip both points to their images
      if (ok)
         ok = sc >= 0 && sc < DEF_SRC_WIDTH && sr >= 0 && sr < DEF_SRC_HEIGHT &&
              dc >= 0 && dc < DEF_DST_WIDTH && dr >= 0 && dr < DEF_DST_HEIGHT;
      if (ok) begin
         res.coords.src_col       = sc[OUT_CW-1:0];
         res.coords.src_row       = sr[OUT_CW-1:0];
         res.coords.dst_col       = dc[OUT_CW-1:0];
         res.coords.dst_row       = dr[OUT_CW-1:0];
         res.coords.src_byte_addr = OUT_AW'(3 * (sr * DEF_SRC_WIDTH + sc));
         res.coords.dst_byte_addr = OUT_AW'(3 * (dr * DEF_DST_WIDTH + dc));
         res.we = 1'b1;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic add_pixel(input int col, input int row);
      bus_cmds.push_back('{CMD_PIXEL, IDX_W'(col), IDX_W'(row), REG_SRC_LEFT, '0});
   endtask

   task automatic add_drain();
      bus_cmds.push_back('{CMD_DRAIN, '0, '0, REG_SRC_LEFT, '0});
   endtask

   // all eight registers, in register order
   task automatic add_geometry(input int sl, input int st, input int sw, input int sh,
                               input int dl, input int dt, input int dw, input int dh);
      int vals [REG_NUM];
      vals = '{sl, st, sw, sh, dl, dt, dw, dh};
      for (int i = 0; i < REG_NUM; i++)
         bus_cmds.push_back('{CMD_WRITE, '0, '0, reg_idx_type'(i), REG_W'(vals[i])});
   endtask

   // mostly small rectangles so that indices land inside; now and then huge
   function automatic int pick_size();
      if ($urandom_range(7) == 0) return int'($urandom_range(1, 4096));
      return int'($urandom_range(1, 40));
   endfunction

   // mostly near the image so that clipping edges get hit
   function automatic int pick_origin();
      if ($urandom_range(5) == 0) return int'($urandom_range(8191)) - 4096;
      return int'($urandom_range(1100)) - 40;
   endfunction

   task automatic add_random_geometry(output int span_w, output int span_h);
      int sw, sh, dw, dh;
      int shape;
      shape = $urandom_range(2);
      sw = pick_size();
      sh = pick_size();
      case (shape)
         0: begin
            dw = sw;
            dh = sh;
         end
         1: begin
            if (sw < 2) sw = 2;
            if (sh < 2) sh = 2;
            dw = $urandom_range(1, sw - 1);
            dh = $urandom_range(1, sh - 1);
         end
         default: begin
            dw = pick_size();
            dh = pick_size();
            if (dw < sw && dh < sh) dh = sh;   // keep it out of shrink mode
         end
      endcase
      add_geometry(pick_origin(), pick_origin(), sw, sh,
                   pick_origin(), pick_origin(), dw, dh);
      // indices run over the source when shrinking, else the destination
      span_w = (sw > dw && sh > dh) ? sw : dw;
      span_h = (sw > dw && sh > dh) ? sh : dh;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int span_w, span_h;
      int col, row;

      // copy mode straddling the image corners
      add_geometry(-3, 1020, 8, 8, 1020, -2, 8, 8);
      add_pixel(0, 0);        // source column left of the image
      add_pixel(3, 0);        // destination row above the image
      add_pixel(3, 2);
      add_pixel(3, 3);        // last source row, last destination column
      add_pixel(4, 3);        // destination column past the right edge
      add_pixel(7, 7);
      add_pixel(8, 0);        // index beyond the rectangle
      add_pixel(0, 8);
      // shrink with the largest source size
      add_geometry(-3000, 0, 4096, 4096, 0, 1, 1000, 4095);
      add_pixel(4095, 4095);
      add_pixel(3000, 0);
      add_pixel(4023, 1022);
      add_pixel(0, 0);
      add_pixel(3000, 1023);
      add_pixel(3000, 1024);
      // origin extremes: nothing lands inside
      add_geometry(4095, -4096, 1, 1, -4096, 4095, 4096, 4096);
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      // grow across a full-size destination
      add_geometry(0, 0, 3, 1024, -5, -3072, 4096, 4096);
      add_pixel(5, 3072);
      add_pixel(4095, 4095);
      add_pixel(1028, 4095);
      add_pixel(1029, 4094);
      // zero-sized source rectangle
      add_geometry(0, 0, 0, 5, 0, 0, 5, 5);
      add_pixel(0, 0);
      add_pixel(1, 1);
      // wider but shorter source still walks the destination
      add_geometry(0, 0, 10, 2, 0, 0, 5, 8);
      add_pixel(4, 7);
      add_pixel(5, 0);

      // random geometries, mostly in-span indices
      for (int phase = 0; phase < 12; phase++) begin
         add_random_geometry(span_w, span_h);
         for (int i = 0; i < 150; i++) begin
            if (phase % 4 == 1 && i == 75)
               add_drain();
            col = ($urandom_range(6) == 0) ? $urandom_range(4095) : $urandom_range(span_w - 1);
            row = ($urandom_range(6) == 0) ? $urandom_range(4095) : $urandom_range(span_h - 1);
            add_pixel(col, row);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sample away from the driving edge
      while (bus_cmds.size() != 0 || req_tvalid || apb_step != APB_IDLE)
         @(negedge clock);
      while (expected_maps.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (mismatches == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver: request stream plus register write and read-back
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      bus_cmd_type head;
      if (reset) begin
         req_tvalid  <= 1'b0;
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         apb_step    <= APB_IDLE;
      end else if (apb_step != APB_IDLE) begin
         case (apb_step)
            APB_WR_SETUP: begin
               csr_penable <= 1'b1;
               apb_step    <= APB_WR_ACCESS;
            end
            APB_WR_ACCESS: begin
               // write lands at this edge; read the same register back
               csr_penable <= 1'b0;
               csr_pwrite  <= 1'b0;
               apb_step    <= APB_RD_SETUP;
            end
            APB_RD_SETUP: begin
               csr_penable <= 1'b1;
               apb_step    <= APB_RD_ACCESS;
            end
            default: begin
               csr_psel    <= 1'b0;
               csr_penable <= 1'b0;
               apb_step    <= APB_IDLE;
            end
         endcase
      end else if (!(req_tvalid && !req_tready)) begin
         // previous transaction (if any) was taken at this edge
         if (bus_cmds.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            head = bus_cmds[0];
            case (head.kind)
               CMD_PIXEL: begin
                  if (!calm && $urandom_range(99) < IDLE_PCT) begin
                     req_tvalid <= 1'b0;
                  end else begin
                     req_tvalid <= 1'b1;
                     req_tdata  <= {head.row, head.col};
                     void'(bus_cmds.pop_front());
                  end
               end
               default: begin
                  // hold off until the pipeline is empty
                  req_tvalid <= 1'b0;
                  if (!req_tvalid && expected_maps.size() == 0) begin
                     void'(bus_cmds.pop_front());
                     if (head.kind == CMD_WRITE) begin
                        csr_psel   <= 1'b1;
                        csr_pwrite <= 1'b1;
                        csr_paddr  <= {head.csr_sel, 2'b00};
                        csr_pwdata <= CSR_DW'(head.value);
                        apb_step   <= APB_WR_SETUP;
                     end
                  end
               end
            endcase
         end
      end
   end

   // response side backpressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // ------------------------------------------------------------------------
   // Monitor: register shadow, prediction on request, in-order compare
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_map_type want;
      rsp_data_type  got;
      if (reset) begin
         // origins 0, sizes 1
         geom = '{'0, '0, REG_W'(1), REG_W'(1), '0, '0, REG_W'(1), REG_W'(1)};
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite)
               geom[csr_paddr[4:2]] = csr_pwdata[REG_W-1:0];
            else
               check_field("csr_prdata", geom[csr_paddr[4:2]], csr_prdata[REG_W-1:0]);
         end
         if (req_tvalid && req_tready) begin
            expected_maps.push_back(map_pixel(req_tdata[IDX_W-1:0],
                                              req_tdata[2*IDX_W-1:IDX_W]));
            sent_items++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_maps.size() == 0) begin
               $error("rsp transaction with no request outstanding");
               mismatches++;
            end else begin
               want = expected_maps.pop_front();
               got  = rsp_tdata;
               check_field("src_col",       want.coords.src_col,       got.src_col);
               check_field("src_row",       want.coords.src_row,       got.src_row);
               check_field("dst_col",       want.coords.dst_col,       got.dst_col);
               check_field("dst_row",       want.coords.dst_row,       got.dst_row);
               check_field("src_byte_addr", want.coords.src_byte_addr, got.src_byte_addr);
               check_field("dst_byte_addr", want.coords.dst_byte_addr, got.dst_byte_addr);
               check_field("tdata pad",     want.coords.pad,           got.pad);
               check_field("write_enable",  want.we,                   rsp_tuser[0]);
            end
         end
      end
   end

   // watchdog: too long with no transaction on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
